>>> hw/rtl/ocma_pkg.sv
`timescale 1ns / 1ps

package ocma_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int FIELD_BITS  = 16;
  localparam int CFG_ADDR_W  = 3;

  localparam logic [0:0] REG_OFFSET        = 1'b0;
  localparam logic [0:0] REG_REPORT_PERIOD = 1'b1;

  localparam logic [FIELD_BITS-1:0] REPORT_PERIOD_RESET = 16'd100;

  typedef struct packed {
    logic                   cycle_end;
    logic [SAMPLE_BITS-1:0] sample;
  } tick_t;

  typedef struct packed {
    logic [FIELD_BITS-1:0] raw_average;
    logic [FIELD_BITS-1:0] corrected_average;
    logic                  indicator;
  } report_t;

endpackage

>>> hw/rtl/offset_corrected_moving_average.sv
`timescale 1ns / 1ps

// Moving average over the last WINDOW samples, reported every report_period
// cycle-end ticks as the truncated average, the average less offset (clamped
// at zero) and a toggling indicator. A tick request without cycle end is
// accepted and dropped; a cycle-end tick passes through UPDATE when no report
// falls due; a reporting tick passes through UPDATE, DIVIDE and FINISH, where
// the bit-serial divider forms sum / fill count one quotient bit a cycle.
// Ticks are taken one at a time; tick_stall is high while one is in work. The
// report sits in an output register, so the next tick is taken while it
// waits. Ring entries not yet written count as zero, so no clearing pass
// follows reset.
module offset_corrected_moving_average #(
  parameter int WINDOW = 100
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  tick_valid,
  output logic                                  tick_stall,
  input  ocma_pkg::tick_t                       tick,
  output logic                                  report_valid,
  input  logic                                  report_stall,
  output ocma_pkg::report_t                     report,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [ocma_pkg::CFG_ADDR_W-1:0]       paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready
);

  localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = ocma_pkg::SAMPLE_BITS + CNT_W;
  localparam int FB    = ocma_pkg::FIELD_BITS;

  typedef enum logic [1:0] {IDLE, UPDATE, DIVIDE, FINISH} state_t;

  state_t                           state;
  logic [FB-1:0]                    offset;
  logic [FB-1:0]                    report_period;
  logic [ocma_pkg::SAMPLE_BITS-1:0] sample;
  logic [POS_W-1:0]                 write_position;
  logic [SUM_W-1:0]                 window_sum;
  logic [CNT_W-1:0]                 fill_count;
  logic [FB-1:0]                    tick_count;
  logic                             indicator_state;

  logic [ocma_pkg::SAMPLE_BITS-1:0] ring_rdata;
  logic [ocma_pkg::SAMPLE_BITS-1:0] old_sample;
  logic [SUM_W-1:0]                 window_sum_next;
  logic [CNT_W-1:0]                 fill_count_next;
  logic [FB-1:0]                    tick_count_next;
  logic                             ring_we;
  logic                             div_start;
  logic                             div_done;
  logic [SUM_W-1:0]                 quotient;
  logic [FB-1:0]                    avg;
  logic                             cfg_write;
  logic                             tick_take;
  logic                             report_free;

  assign pready      = 1'b1;
  assign cfg_write   = psel && penable && pwrite;
  assign prdata      = (paddr[2] == ocma_pkg::REG_REPORT_PERIOD) ? 32'(report_period)
                                                                 : 32'(offset);
  assign tick_stall  = (state != IDLE);
  assign tick_take   = tick_valid && !tick_stall && tick.cycle_end;
  assign report_free = !report_valid || !report_stall;

  assign old_sample      = (fill_count == CNT_W'(WINDOW)) ? ring_rdata : '0;
  assign window_sum_next = window_sum - SUM_W'(old_sample) + SUM_W'(sample);
  assign fill_count_next = (fill_count == CNT_W'(WINDOW)) ? fill_count : fill_count + 1'b1;
  assign tick_count_next = tick_count + 1'b1;
  assign ring_we         = (state == UPDATE);
  assign div_start       = (state == UPDATE) && (tick_count_next == report_period);
  assign avg             = quotient[FB-1:0];

  ocma_ring #(
    .DEPTH  (WINDOW),
    .ADDR_W (POS_W)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .addr  (write_position),
    .wdata (sample),
    .rdata (ring_rdata)
  );

  ocma_div #(
    .DVD_W (SUM_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (window_sum_next),
    .divisor  (fill_count_next),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      offset        <= '0;
      report_period <= ocma_pkg::REPORT_PERIOD_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        ocma_pkg::REG_OFFSET:        offset        <= pwdata[FB-1:0];
        ocma_pkg::REG_REPORT_PERIOD: report_period <= pwdata[FB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= IDLE;
      write_position  <= '0;
      window_sum      <= '0;
      fill_count      <= '0;
      tick_count      <= '0;
      indicator_state <= 1'b0;
      report_valid    <= 1'b0;
    end else begin
      if (state == FINISH && report_free) begin
        report_valid <= 1'b1;
      end else if (report_valid && !report_stall) begin
        report_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (tick_take) begin
            sample <= tick.sample;
            state  <= UPDATE;
          end
        end
        UPDATE: begin
          window_sum     <= window_sum_next;
          fill_count     <= fill_count_next;
          write_position <= (write_position == POS_W'(WINDOW - 1)) ? '0
                                                                   : write_position + 1'b1;
          if (div_start) begin
            tick_count      <= '0;
            indicator_state <= !indicator_state;
            state           <= DIVIDE;
          end else begin
            tick_count <= tick_count_next;
            state      <= IDLE;
          end
        end
        DIVIDE: begin
          if (div_done) begin
            state <= FINISH;
          end
        end
        FINISH: begin
          if (report_free) begin
            report.raw_average       <= avg;
            report.corrected_average <= (avg > offset) ? avg - offset : '0;
            report.indicator         <= indicator_state;
            state                    <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/ocma_ring.sv
`timescale 1ns / 1ps

module ocma_ring #(
  parameter int DEPTH  = 100,
  parameter int ADDR_W = 7
) (
  input  logic                             clk,
  input  logic                             we,
  input  logic [ADDR_W-1:0]                addr,
  input  logic [ocma_pkg::SAMPLE_BITS-1:0] wdata,
  output logic [ocma_pkg::SAMPLE_BITS-1:0] rdata
);

  logic [ocma_pkg::SAMPLE_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

>>> hw/rtl/ocma_div.sv
`timescale 1ns / 1ps

module ocma_div #(
  parameter int DVD_W = 23,
  parameter int DVS_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [DVS_W-1:0]  dvs;
  logic [DVS_W-1:0]  rem;
  logic [DVD_W-1:0]  shreg;
  logic [DVS_W:0]    trial;
  logic              fits;

  assign trial    = {rem, shreg[DVD_W-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = shreg;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        step  <= '0;
        dvs   <= divisor;
        rem   <= '0;
        shreg <= dividend;
      end else if (busy) begin
        if (fits) begin
          rem <= DVS_W'(trial - {1'b0, dvs});
        end else begin
          rem <= trial[DVS_W-1:0];
        end
        shreg <= {shreg[DVD_W-2:0], fits};
        step  <= step + 1'b1;
        if (step == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

>>> test/tb_offset_corrected_moving_average.sv
`timescale 1ns / 1ps

module tb_offset_corrected_moving_average;

  localparam int WINDOW        = 100;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES   = 300;

  localparam logic [ocma_pkg::CFG_ADDR_W-1:0] ADDR_OFFSET        =
    {ocma_pkg::REG_OFFSET, 2'b00};
  localparam logic [ocma_pkg::CFG_ADDR_W-1:0] ADDR_REPORT_PERIOD =
    {ocma_pkg::REG_REPORT_PERIOD, 2'b00};

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            tick_valid = 1'b0;
  logic                            tick_stall;
  ocma_pkg::tick_t                 tick = '0;
  logic                            report_valid;
  logic                            report_stall = 1'b0;
  ocma_pkg::report_t               report;
  logic                            psel = 1'b0;
  logic                            penable = 1'b0;
  logic                            pwrite = 1'b0;
  logic [ocma_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]                     pwdata = '0;
  logic [31:0]                     prdata;
  logic                            pready;

  offset_corrected_moving_average dut (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // averaging model state
  logic [15:0]       ring [WINDOW] = '{default: '0};
  int                wr_pos = 0;
  int unsigned       window_sum = 0;
  int                fill = 0;
  logic [15:0]       tick_count_model = '0;
  logic              indicator_model = 1'b0;
  logic [15:0]       offset_cfg = '0;
  logic [15:0]       period_cfg = ocma_pkg::REPORT_PERIOD_RESET;
  ocma_pkg::report_t expected_reports [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;

  int ticks_sent = 0;
  int ignored_ticks = 0;
  int reports_checked = 0;
  int reg_writes = 0;
  int mismatches = 0;
  logic [15:0] sample_level = '0;

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #(64'd60_000_000);
    $display("FAIL");
    $finish;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served  <= hold_requests;
      hold_left    <= HOLD_CYCLES;
      report_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left    <= hold_left - 1;
      report_stall <= 1'b1;
    end else begin
      report_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin : check_reports
    ocma_pkg::report_t want;
    if (!rst && report_valid && !report_stall) begin
      if (expected_reports.size() == 0) begin
        $error("unexpected report: raw_average %0d corrected_average %0d indicator %0d",
               report.raw_average, report.corrected_average, report.indicator);
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        reports_checked++;
        if (report.raw_average !== want.raw_average) begin
          $error("raw_average expected %0d got %0d", want.raw_average, report.raw_average);
          mismatches++;
        end
        if (report.corrected_average !== want.corrected_average) begin
          $error("corrected_average expected %0d got %0d",
                 want.corrected_average, report.corrected_average);
          mismatches++;
        end
        if (report.indicator !== want.indicator) begin
          $error("indicator expected %0d got %0d", want.indicator, report.indicator);
          mismatches++;
        end
      end
    end
  end

  task automatic predict_tick(input ocma_pkg::tick_t t);
    ocma_pkg::report_t r;
    logic [15:0]       avg;
    ticks_sent++;
    if (!t.cycle_end) begin
      ignored_ticks++;
      return;
    end
    tick_count_model = tick_count_model + 16'd1;
    window_sum = window_sum - ring[wr_pos] + t.sample;
    ring[wr_pos] = t.sample;
    wr_pos = (wr_pos == WINDOW - 1) ? 0 : wr_pos + 1;
    if (fill < WINDOW) fill++;
    if (tick_count_model != period_cfg) return;
    tick_count_model = '0;
    indicator_model = ~indicator_model;
    avg = 16'(window_sum / fill);
    r.raw_average = avg;
    r.corrected_average = (avg > offset_cfg) ? avg - offset_cfg : 16'd0;
    r.indicator = indicator_model;
    expected_reports.push_back(r);
  endtask

  function automatic logic [15:0] next_average(input logic [15:0] s);
    return 16'((window_sum - ring[wr_pos] + s) / ((fill < WINDOW) ? fill + 1 : fill));
  endfunction

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2, 3, 4: return sample_level ^ 16'($urandom_range(255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_tick(input logic ce, input logic [15:0] s);
    ocma_pkg::tick_t t;
    t.cycle_end = ce;
    t.sample = s;
    while ($urandom_range(99) < send_idle_pct) begin
      tick_valid <= 1'b0;
      tick <= ocma_pkg::tick_t'($urandom);
      @(posedge clk);
    end
    tick_valid <= 1'b1;
    tick <= t;
    @(posedge clk);
    while (tick_stall) @(posedge clk);
    predict_tick(t);
  endtask

  task automatic wait_reports();
    tick_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
  endtask

  // a non-reporting tick may still be in work after the last report
  task automatic wait_idle();
    wait_reports();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [ocma_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [15:0] value);
    wait_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    reg_writes++;
    if (addr == ADDR_OFFSET) offset_cfg = value;
    else if (addr == ADDR_REPORT_PERIOD) period_cfg = value;
  endtask

  task automatic read_reg(input logic [ocma_pkg::CFG_ADDR_W-1:0] addr,
                          input logic [15:0] want, input string name);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[15:0] !== want) begin
      $error("%s expected %0d got %0d", name, want, prdata[15:0]);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // period above the running count, so no wrap is needed
  function automatic logic [15:0] safe_period();
    logic [15:0] p;
    p = 16'($urandom_range(1, 12));
    if (p <= tick_count_model) p = tick_count_model + 16'($urandom_range(1, 4));
    return p;
  endfunction

  task automatic test_reset_state();
    read_reg(ADDR_OFFSET, 16'd0, "offset");
    read_reg(ADDR_REPORT_PERIOD, ocma_pkg::REPORT_PERIOD_RESET, "report_period");
    for (int i = 0; i < 100; i++) begin
      if (i % 17 == 3) send_tick(1'b0, 16'h0000);
      send_tick(1'b1, 16'hFFFF);
    end
    wait_reports();
  endtask

  task automatic test_directed();
    logic [15:0] s;
    logic [15:0] target;
    write_reg(ADDR_OFFSET, 16'hFFFF);
    write_reg(ADDR_REPORT_PERIOD, 16'd1);
    read_reg(ADDR_OFFSET, 16'hFFFF, "offset");
    read_reg(ADDR_REPORT_PERIOD, 16'd1, "report_period");
    send_tick(1'b1, 16'h0000);
    send_tick(1'b1, 16'hFFFF);
    send_tick(1'b1, 16'h5555);
    send_tick(1'b1, 16'hAAAA);
    send_tick(1'b0, 16'hFFFF);
    send_tick(1'b0, 16'h0000);
    send_tick(1'b1, 16'h0001);
    // average equal to, just above and just below the offset
    for (int d = -1; d <= 1; d++) begin
      s = 16'($urandom);
      target = next_average(s);
      if (d < 0 && target == 16'h0000) target = 16'h0001;
      if (d > 0 && target == 16'hFFFF) target = 16'hFFFE;
      write_reg(ADDR_OFFSET, 16'(int'(target) + d));
      send_tick(1'b1, s);
    end
    write_reg(ADDR_OFFSET, 16'd0);
    send_tick(1'b1, 16'h8000);
    send_tick(1'b1, 16'h7FFF);
    write_reg(ADDR_REPORT_PERIOD, 16'hFFFF);
    repeat (3) send_tick(1'b1, 16'($urandom));
    write_reg(ADDR_REPORT_PERIOD, 16'd5);
    repeat (2) send_tick(1'b1, 16'($urandom));
    wait_reports();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reg(ADDR_REPORT_PERIOD, safe_period() > 16'd1 ? safe_period() : 16'd1);
    write_reg(ADDR_REPORT_PERIOD, (tick_count_model == 0) ? 16'd1 : tick_count_model + 16'd1);
    hold_requests++;
    for (int i = 0; i < 40; i++) send_tick(1'b1, 16'($urandom));
    wait_reports();
    // sender pause until all reports are back, then resume
    for (int i = 0; i < 10; i++) send_tick(1'b1, 16'($urandom));
    wait_reports();
    for (int i = 0; i < 10; i++) send_tick($urandom_range(3) != 0, 16'($urandom));
    wait_reports();
  endtask

  task automatic test_random(input int send_pct, input int recv_pct, input int count);
    int          sent;
    int          chunk;
    logic [15:0] off;
    logic [15:0] avg;
    sent = 0;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (sent < count) begin
      avg = (fill > 0) ? 16'(window_sum / fill) : 16'd0;
      case ($urandom_range(5))
        0:       off = 16'h0000;
        1:       off = 16'hFFFF;
        2, 3:    off = 16'(int'(avg) + $urandom_range(64) - 32);
        default: off = 16'($urandom);
      endcase
      write_reg(ADDR_OFFSET, off);
      write_reg(ADDR_REPORT_PERIOD, safe_period());
      sample_level = 16'($urandom);
      chunk = $urandom_range(20, 60);
      for (int i = 0; i < chunk; i++) begin
        send_tick($urandom_range(99) < 85, pick_sample());
        sent++;
      end
    end
    wait_reports();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_directed();
    test_backpressure();
    test_random(28, 73, 400);
    test_random(73, 28, 400);
    test_random(0, 0, 400);
    wait_idle();
    $display("Sent %0d ticks (%0d without cycle end), checked %0d reports,",
             ticks_sent, ignored_ticks, reports_checked);
    $display("with %0d register writes, output hold-off and offset clamp boundaries.",
             reg_writes);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
